### rtl/cai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU package
// Opcodes, status codes and the transaction payload types shared by the
// block and its channels.
// ----------------------------------------------------------------------------
package cai_pkg;

	// Widths of the channel fields, fixed by the interface definition.
	localparam int OP_W    = 5;
	localparam int FIELD_W = 64;
	localparam int STAT_W  = 2;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 5'd0,
		OP_SUB    = 5'd1,
		OP_MUL    = 5'd2,
		OP_DIV    = 5'd3,
		OP_REM    = 5'd4,
		OP_MOD    = 5'd5,
		OP_MAX    = 5'd6,
		OP_MIN    = 5'd7,
		OP_AND    = 5'd8,
		OP_OR     = 5'd9,
		OP_XOR    = 5'd10,
		OP_SHL    = 5'd11,
		OP_SHR    = 5'd12,
		OP_NOT    = 5'd13,
		OP_NEG    = 5'd14,
		OP_ABS    = 5'd15,
		OP_PRED   = 5'd16,
		OP_SUCC   = 5'd17,
		OP_SQUARE = 5'd18,
		OP_CUBE   = 5'd19,
		OP_EQ     = 5'd20,
		OP_NE     = 5'd21,
		OP_LT     = 5'd22,
		OP_GT     = 5'd23,
		OP_LE     = 5'd24,
		OP_GE     = 5'd25
	} op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVF   = 2'd1,
		ST_DIV0  = 2'd2,
		ST_SHIFT = 2'd3
	} status_t;

	// Command transaction payload.
	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic signed [FIELD_W-1:0] operand_a;
		logic signed [FIELD_W-1:0] operand_b;
	} cmd_t;

	// Response transaction payload.
	typedef struct packed {
		logic signed [FIELD_W-1:0] result;
		logic [STAT_W-1:0]         status;
	} rsp_t;

endpackage

### rtl/cai_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel: a transaction moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface cai_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### rtl/cai_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked ALU front stage
// Decodes a transaction, computes the operations that need no cell chain and
// prepares magnitudes for the divide and multiply cell chains.
// ----------------------------------------------------------------------------
module cai_front #(
	parameter int W      = 64,
	parameter int SIDE_W = 3 * W + 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cai_pkg::OP_W-1:0]    in_op,
	input  logic [W-1:0]                in_a,
	input  logic [W-1:0]                in_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [SIDE_W-1:0]           side_o,
	output logic [W-1:0]                quo_o,
	output logic [W-1:0]                dvs_o,
	output logic [2*W-1:0]              mcand_o,
	output logic [W-1:0]                mplier_o
);

	localparam logic [W-1:0] MIN_V       = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_V       = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SHIFT_LIMIT = W'(W);

	logic                         sa, sb;
	logic [W-1:0]                 am, bm;
	logic [W:0]                   sum, dif;
	logic                         a_min, a_max, lt, eq, shift_bad;
	logic [W-1:0]                 qr;
	logic [cai_pkg::STAT_W-1:0]   qs;
	logic                         valid_q;
	logic [SIDE_W-1:0]            side_q;
	logic [W-1:0]                 quo_q, dvs_q, mplier_q;
	logic [2*W-1:0]               mcand_q;

	// Signs, magnitudes and the shared add, subtract and compare.
	always_comb begin
		sa        = in_a[W-1];
		sb        = in_b[W-1];
		am        = sa ? (~in_a + 1'b1) : in_a;
		bm        = sb ? (~in_b + 1'b1) : in_b;
		sum       = {sa, in_a} + {sb, in_b};
		dif       = {sa, in_a} - {sb, in_b};
		a_min     = (in_a == MIN_V);
		a_max     = (in_a == MAX_V);
		lt        = ($signed(in_a) < $signed(in_b));
		eq        = (in_a == in_b);
		shift_bad = sb || (in_b >= SHIFT_LIMIT);
	end

	// Operations that need no cell chain; the chained ones are finished at the back end.
	always_comb begin
		qr = '0;
		qs = cai_pkg::ST_OK;
		case (in_op)
			cai_pkg::OP_ADD: begin
				if (sum[W] != sum[W-1]) qs = cai_pkg::ST_OVF;
				qr = sum[W-1:0];
			end
			cai_pkg::OP_SUB: begin
				if (dif[W] != dif[W-1]) qs = cai_pkg::ST_OVF;
				qr = dif[W-1:0];
			end
			cai_pkg::OP_MAX: qr = lt ? in_b : in_a;
			cai_pkg::OP_MIN: qr = lt ? in_a : in_b;
			cai_pkg::OP_AND: qr = in_a & in_b;
			cai_pkg::OP_OR:  qr = in_a | in_b;
			cai_pkg::OP_XOR: qr = in_a ^ in_b;
			cai_pkg::OP_SHL: begin
				if (shift_bad) qs = cai_pkg::ST_SHIFT;
				qr = in_a << in_b;
			end
			cai_pkg::OP_SHR: begin
				if (shift_bad) qs = cai_pkg::ST_SHIFT;
				qr = in_a >> in_b;
			end
			cai_pkg::OP_NOT: qr = ~in_a;
			cai_pkg::OP_NEG: begin
				if (a_min) qs = cai_pkg::ST_OVF;
				qr = ~in_a + 1'b1;
			end
			cai_pkg::OP_ABS: begin
				if (a_min) qs = cai_pkg::ST_OVF;
				qr = am;
			end
			cai_pkg::OP_PRED: begin
				if (a_min) qs = cai_pkg::ST_OVF;
				qr = in_a - 1'b1;
			end
			cai_pkg::OP_SUCC: begin
				if (a_max) qs = cai_pkg::ST_OVF;
				qr = in_a + 1'b1;
			end
			cai_pkg::OP_EQ: qr = W'(eq);
			cai_pkg::OP_NE: qr = W'(!eq);
			cai_pkg::OP_LT: qr = W'(lt);
			cai_pkg::OP_GT: qr = W'(!lt && !eq);
			cai_pkg::OP_LE: qr = W'(lt || eq);
			cai_pkg::OP_GE: qr = W'(!lt);
			default: begin
				qr = '0;
				qs = cai_pkg::ST_OK;
			end
		endcase
	end

	assign in_ready = !valid_q || out_ready;

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			side_q   <= {in_op, qr, qs, sa, sb, am, bm};
			quo_q    <= am;
			dvs_q    <= bm;
			mcand_q  <= {{W{1'b0}}, am};
			mplier_q <= (in_op == cai_pkg::OP_MUL) ? bm : am;
		end
	end

	assign out_valid = valid_q;
	assign side_o    = side_q;
	assign quo_o     = quo_q;
	assign dvs_o     = dvs_q;
	assign mcand_o   = mcand_q;
	assign mplier_o  = mplier_q;

endmodule

### rtl/cai_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked ALU chain cell
// One shift-add multiply step per cell and, with DIV_EN set, one restoring
// divide step; each cell has its own valid/ready stage register.
// ----------------------------------------------------------------------------
module cai_cell #(
	parameter int W      = 64,
	parameter int SIDE_W = 3 * W + 9,
	parameter bit DIV_EN = 1'b1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SIDE_W-1:0] side_i,
	input  logic [W:0]        rem_i,
	input  logic [W-1:0]      quo_i,
	input  logic [W-1:0]      dvs_i,
	input  logic [2*W-1:0]    acc_i,
	input  logic [2*W-1:0]    mcand_i,
	input  logic [W-1:0]      mplier_i,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SIDE_W-1:0] side_o,
	output logic [W:0]        rem_o,
	output logic [W-1:0]      quo_o,
	output logic [W-1:0]      dvs_o,
	output logic [2*W-1:0]    acc_o,
	output logic [2*W-1:0]    mcand_o,
	output logic [W-1:0]      mplier_o
);

	logic              valid_q;
	logic              load;
	logic [SIDE_W-1:0] side_q;
	logic [2*W-1:0]    acc_q, mcand_q;
	logic [W-1:0]      mplier_q;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Multiply step: add the shifted multiplicand when the low multiplier bit is set.
	always_ff @(posedge clk) begin
		if (load) begin
			side_q   <= side_i;
			acc_q    <= mplier_i[0] ? (acc_i + mcand_i) : acc_i;
			mcand_q  <= {mcand_i[2*W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_i[W-1:1]};
		end
	end

	assign out_valid = valid_q;
	assign side_o    = side_q;
	assign acc_o     = acc_q;
	assign mcand_o   = mcand_q;
	assign mplier_o  = mplier_q;

	generate
		if (DIV_EN) begin : g_div
			logic [W:0]   rem_sh;
			logic [W+1:0] diff;
			logic         fits;
			logic [W:0]   rem_q;
			logic [W-1:0] quo_q, dvs_q;

			// Divide step: bring in the next dividend bit and try the subtract.
			always_comb begin
				rem_sh = {rem_i[W-1:0], quo_i[W-1]};
				diff   = {1'b0, rem_sh} - {2'b00, dvs_i};
				fits   = !diff[W+1];
			end

			always_ff @(posedge clk) begin
				if (load) begin
					rem_q <= fits ? diff[W:0] : rem_sh;
					quo_q <= {quo_i[W-2:0], fits};
					dvs_q <= dvs_i;
				end
			end

			assign rem_o = rem_q;
			assign quo_o = quo_q;
			assign dvs_o = dvs_q;
		end else begin : g_no_div
			assign rem_o = '0;
			assign quo_o = '0;
			assign dvs_o = '0;
		end
	endgenerate

endmodule

### rtl/cai_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked ALU back end
// Applies signs to the chain results, checks product and divide errors,
// selects the result and holds it in the output register.
// ----------------------------------------------------------------------------
module cai_back #(
	parameter int W      = 64,
	parameter int SIDE_W = 3 * W + 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SIDE_W-1:0]                   side_i,
	input  logic [W-1:0]                        quo_i,
	input  logic [W-1:0]                        rem_i,
	input  logic                                ovf1_i,
	input  logic [2*W-1:0]                      acc_i,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cai_pkg::FIELD_W-1:0]  result,
	output logic [cai_pkg::STAT_W-1:0]          status
);

	localparam logic [2*W-1:0] HALF_P = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]   HALF_W = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]   ONE_W  = {{(W-1){1'b0}}, 1'b1};

	logic [cai_pkg::OP_W-1:0]    op;
	logic [W-1:0]                qr, am, bm;
	logic [cai_pkg::STAT_W-1:0]  qs;
	logic                        sa, sb;
	logic                        p_neg, p_ovf, b_zero, d_ovf;
	logic [W-1:0]                p_val, q_val, r_val, m_val;
	logic signed [W-1:0]         res;
	logic [cai_pkg::STAT_W-1:0]  st;
	logic                        valid_q;
	logic signed [cai_pkg::FIELD_W-1:0] result_q;
	logic [cai_pkg::STAT_W-1:0]  status_q;

	// Unpack the carried fields.
	always_comb begin
		op = side_i[3*W+8:3*W+4];
		qr = side_i[3*W+3:2*W+4];
		qs = side_i[2*W+3:2*W+2];
		sa = side_i[2*W+1];
		sb = side_i[2*W];
		am = side_i[2*W-1:W];
		bm = side_i[W-1:0];
	end

	// Signed product and quotient forms, with their error checks.
	always_comb begin
		p_neg = 1'b0;
		if (op == cai_pkg::OP_MUL) p_neg = sa ^ sb;
		if (op == cai_pkg::OP_CUBE) p_neg = sa;
		p_ovf = p_neg ? (acc_i > HALF_P) : (acc_i >= HALF_P);
		if (op == cai_pkg::OP_CUBE && ovf1_i) p_ovf = 1'b1;
		p_val  = p_neg ? (~acc_i[W-1:0] + 1'b1) : acc_i[W-1:0];
		b_zero = (bm == '0);
		d_ovf  = sa && (am == HALF_W) && sb && (bm == ONE_W);
		q_val  = (sa ^ sb) ? (~quo_i + 1'b1) : quo_i;
		r_val  = sa ? (~rem_i + 1'b1) : rem_i;
		m_val  = (sa && (rem_i != '0)) ? (bm - rem_i) : rem_i;
	end

	// Result selection; any error forces a zero result.
	always_comb begin
		res = qr;
		st  = qs;
		case (op)
			cai_pkg::OP_MUL, cai_pkg::OP_SQUARE, cai_pkg::OP_CUBE: begin
				res = p_val;
				st  = p_ovf ? cai_pkg::ST_OVF : cai_pkg::ST_OK;
			end
			cai_pkg::OP_DIV: begin
				res = q_val;
				if (b_zero) st = cai_pkg::ST_DIV0;
				else if (d_ovf) st = cai_pkg::ST_OVF;
				else st = cai_pkg::ST_OK;
			end
			cai_pkg::OP_REM: begin
				res = r_val;
				st  = b_zero ? cai_pkg::ST_DIV0 : cai_pkg::ST_OK;
			end
			cai_pkg::OP_MOD: begin
				res = m_val;
				st  = b_zero ? cai_pkg::ST_DIV0 : cai_pkg::ST_OK;
			end
			default: begin
				res = qr;
				st  = qs;
			end
		endcase
		if (st != cai_pkg::ST_OK) res = '0;
	end

	assign in_ready = !valid_q || out_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			result_q <= cai_pkg::FIELD_W'(res);
			status_q <= st;
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;
	assign status    = status_q;

endmodule

### rtl/checked_int64_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overflow-checked integer ALU
// Signed DATA_WIDTH-bit arithmetic, logic, shift and compare operations with
// an error status, built as a pipeline of divide/multiply cells.
// ----------------------------------------------------------------------------
// The ALU accepts one command transaction every clock cycle while the
// response side does not stall, and returns one response per command in
// order. Every operation passes 2*DATA_WIDTH + 2 registers: one front stage,
// DATA_WIDTH cells that each take one restoring divide step and one shift-add
// multiply step, DATA_WIDTH more multiply cells for the second product of
// cube, and the output register.
// Every stage has its own valid/ready register, so commands keep entering
// while a response waits to be taken, until the pipeline is full.

module checked_int64_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	cai_stream_if.sink   cmd,
	cai_stream_if.source rsp
);

	localparam int W       = DATA_WIDTH;
	localparam int SIDE_W  = 3 * W + 9;
	localparam int SIDE2_W = SIDE_W + 2 * W + 1;

	// Chain one: divide steps and the first product.
	logic              c1_valid  [W+1];
	logic              c1_ready  [W+1];
	logic [SIDE_W-1:0] c1_side   [W+1];
	logic [W:0]        c1_rem    [W+1];
	logic [W-1:0]      c1_quo    [W+1];
	logic [W-1:0]      c1_dvs    [W+1];
	logic [2*W-1:0]    c1_acc    [W+1];
	logic [2*W-1:0]    c1_mcand  [W+1];
	logic [W-1:0]      c1_mplier [W+1];

	// Chain two: second product for cube, pass-through of the product otherwise.
	logic               c2_valid  [W+1];
	logic               c2_ready  [W+1];
	logic [SIDE2_W-1:0] c2_side   [W+1];
	logic [W:0]         c2_rem    [W+1];
	logic [W-1:0]       c2_quo    [W+1];
	logic [W-1:0]       c2_dvs    [W+1];
	logic [2*W-1:0]     c2_acc    [W+1];
	logic [2*W-1:0]     c2_mcand  [W+1];
	logic [W-1:0]       c2_mplier [W+1];

	logic [cai_pkg::OP_W-1:0] mid_op;
	logic [W-1:0]             mid_am;
	logic                     mid_ovf;

	cai_front #(
		.W      (W),
		.SIDE_W (SIDE_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_op     (cmd.data.operation),
		.in_a      (cmd.data.operand_a[W-1:0]),
		.in_b      (cmd.data.operand_b[W-1:0]),
		.out_valid (c1_valid[0]),
		.out_ready (c1_ready[0]),
		.side_o    (c1_side[0]),
		.quo_o     (c1_quo[0]),
		.dvs_o     (c1_dvs[0]),
		.mcand_o   (c1_mcand[0]),
		.mplier_o  (c1_mplier[0])
	);

	assign c1_rem[0] = '0;
	assign c1_acc[0] = '0;

	generate
		for (genvar i = 0; i < W; i++) begin : g_c1
			cai_cell #(
				.W      (W),
				.SIDE_W (SIDE_W),
				.DIV_EN (1'b1)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (c1_valid[i]),
				.in_ready  (c1_ready[i]),
				.side_i    (c1_side[i]),
				.rem_i     (c1_rem[i]),
				.quo_i     (c1_quo[i]),
				.dvs_i     (c1_dvs[i]),
				.acc_i     (c1_acc[i]),
				.mcand_i   (c1_mcand[i]),
				.mplier_i  (c1_mplier[i]),
				.out_valid (c1_valid[i+1]),
				.out_ready (c1_ready[i+1]),
				.side_o    (c1_side[i+1]),
				.rem_o     (c1_rem[i+1]),
				.quo_o     (c1_quo[i+1]),
				.dvs_o     (c1_dvs[i+1]),
				.acc_o     (c1_acc[i+1]),
				.mcand_o   (c1_mcand[i+1]),
				.mplier_o  (c1_mplier[i+1])
			);
		end
	endgenerate

	// Between the chains: flag a square that already overflows and pick the
	// second multiplier (|a| for cube, one otherwise).
	always_comb begin
		mid_op  = c1_side[W][SIDE_W-1:SIDE_W-cai_pkg::OP_W];
		mid_am  = c1_side[W][2*W-1:W];
		mid_ovf = |c1_acc[W][2*W-1:W-1];
	end

	assign c2_valid[0]  = c1_valid[W];
	assign c1_ready[W]  = c2_ready[0];
	assign c2_side[0]   = {c1_side[W], c1_quo[W], c1_rem[W][W-1:0], mid_ovf};
	assign c2_rem[0]    = '0;
	assign c2_quo[0]    = '0;
	assign c2_dvs[0]    = '0;
	assign c2_acc[0]    = '0;
	assign c2_mcand[0]  = c1_acc[W];
	assign c2_mplier[0] = (mid_op == cai_pkg::OP_CUBE) ? mid_am : {{(W-1){1'b0}}, 1'b1};

	generate
		for (genvar j = 0; j < W; j++) begin : g_c2
			cai_cell #(
				.W      (W),
				.SIDE_W (SIDE2_W),
				.DIV_EN (1'b0)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (c2_valid[j]),
				.in_ready  (c2_ready[j]),
				.side_i    (c2_side[j]),
				.rem_i     (c2_rem[j]),
				.quo_i     (c2_quo[j]),
				.dvs_i     (c2_dvs[j]),
				.acc_i     (c2_acc[j]),
				.mcand_i   (c2_mcand[j]),
				.mplier_i  (c2_mplier[j]),
				.out_valid (c2_valid[j+1]),
				.out_ready (c2_ready[j+1]),
				.side_o    (c2_side[j+1]),
				.rem_o     (c2_rem[j+1]),
				.quo_o     (c2_quo[j+1]),
				.dvs_o     (c2_dvs[j+1]),
				.acc_o     (c2_acc[j+1]),
				.mcand_o   (c2_mcand[j+1]),
				.mplier_o  (c2_mplier[j+1])
			);
		end
	endgenerate

	cai_back #(
		.W      (W),
		.SIDE_W (SIDE_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c2_valid[W]),
		.in_ready  (c2_ready[W]),
		.side_i    (c2_side[W][SIDE2_W-1:2*W+1]),
		.quo_i     (c2_side[W][2*W:W+1]),
		.rem_i     (c2_side[W][W:1]),
		.ovf1_i    (c2_side[W][0]),
		.acc_i     (c2_acc[W]),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.result    (rsp.data.result),
		.status    (rsp.data.status)
	);

endmodule

### test/checked_int64_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU testbench
// Drives directed and random commands through the valid/ready channels with
// random gaps and stalls, predicts each response in SystemVerilog and checks
// result and status in order.
// ----------------------------------------------------------------------------
module checked_int64_alu_tb;

	localparam longint MAX64 = 64'sh7fff_ffff_ffff_ffff;
	localparam longint MIN64 = 64'sh8000_0000_0000_0000;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_RANDOM = 1300;

	// Directed row: command, whether the answer is typed in, and that answer.
	typedef struct {
		cai_pkg::cmd_t cmd;
		bit            known;
		cai_pkg::rsp_t rsp;
	} vec_t;

	logic          clk;
	logic          arst_n;
	int            errors;
	int            idle_cycles = 0;
	bit            stim_done;
	cai_pkg::rsp_t rsp_expected_q[$];

	cai_stream_if #(.T(cai_pkg::cmd_t)) cmd_if ();
	cai_stream_if #(.T(cai_pkg::rsp_t)) rsp_if ();

	checked_int64_alu i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.rsp(rsp_if)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Overflow-checked product of two 64-bit values.
	function automatic bit product_fits(longint x, longint y, output longint p);
		logic signed [127:0] full;
		full = 128'(x) * 128'(y);
		p = full[63:0];
		return full == 128'(p);
	endfunction

	// Computes the response for one command at the 64-bit width.
	function automatic cai_pkg::rsp_t alu_answer(cai_pkg::cmd_t c);
		longint a, b, r, t;
		logic [1:0] st;
		logic signed [64:0] wide;
		a = c.operand_a;
		b = c.operand_b;
		r = 0;
		st = cai_pkg::ST_OK;
		case (c.operation)
			cai_pkg::OP_ADD: begin
				wide = 65'(a) + 65'(b);
				if (wide != 65'(longint'(wide[63:0]))) st = cai_pkg::ST_OVF;
				else r = wide[63:0];
			end
			cai_pkg::OP_SUB: begin
				wide = 65'(a) - 65'(b);
				if (wide != 65'(longint'(wide[63:0]))) st = cai_pkg::ST_OVF;
				else r = wide[63:0];
			end
			cai_pkg::OP_MUL: if (!product_fits(a, b, r)) st = cai_pkg::ST_OVF;
			cai_pkg::OP_DIV: begin
				if (b == 0) st = cai_pkg::ST_DIV0;
				else if (a == MIN64 && b == -1) st = cai_pkg::ST_OVF;
				else r = a / b;
			end
			cai_pkg::OP_REM, cai_pkg::OP_MOD: begin
				if (b == 0) st = cai_pkg::ST_DIV0;
				else begin
					r = (a == MIN64 && b == -1) ? 0 : a % b;
					// Euclidean mod lifts a negative remainder by |b|.
					if (c.operation == cai_pkg::OP_MOD && r < 0)
						r = r + (b < 0 ? -b : b);
				end
			end
			cai_pkg::OP_MAX: r = a > b ? a : b;
			cai_pkg::OP_MIN: r = a < b ? a : b;
			cai_pkg::OP_AND: r = a & b;
			cai_pkg::OP_OR:  r = a | b;
			cai_pkg::OP_XOR: r = a ^ b;
			cai_pkg::OP_SHL, cai_pkg::OP_SHR: begin
				if (b < 0 || b >= 64) st = cai_pkg::ST_SHIFT;
				else if (c.operation == cai_pkg::OP_SHL) r = a << b;
				else r = longint'(64'(a) >> b);
			end
			cai_pkg::OP_NOT: r = ~a;
			cai_pkg::OP_NEG: if (a == MIN64) st = cai_pkg::ST_OVF; else r = -a;
			cai_pkg::OP_ABS: if (a == MIN64) st = cai_pkg::ST_OVF; else r = a < 0 ? -a : a;
			cai_pkg::OP_PRED: if (a == MIN64) st = cai_pkg::ST_OVF; else r = a - 1;
			cai_pkg::OP_SUCC: if (a == MAX64) st = cai_pkg::ST_OVF; else r = a + 1;
			cai_pkg::OP_SQUARE: if (!product_fits(a, a, r)) st = cai_pkg::ST_OVF;
			cai_pkg::OP_CUBE:
				if (!product_fits(a, a, t) || !product_fits(t, a, r)) st = cai_pkg::ST_OVF;
			cai_pkg::OP_EQ: r = longint'(a == b);
			cai_pkg::OP_NE: r = longint'(a != b);
			cai_pkg::OP_LT: r = longint'(a < b);
			cai_pkg::OP_GT: r = longint'(a > b);
			cai_pkg::OP_LE: r = longint'(a <= b);
			cai_pkg::OP_GE: r = longint'(a >= b);
			default: r = 0;
		endcase
		if (st != cai_pkg::ST_OK) r = 0;
		return '{result: r, status: st};
	endfunction

	function automatic vec_t row(logic [4:0] op, longint a, longint b,
			bit known = 0, longint r = 0, logic [1:0] st = cai_pkg::ST_OK);
		vec_t v;
		v.cmd = '{operation: op, operand_a: a, operand_b: b};
		v.known = known;
		v.rsp = '{result: r, status: st};
		return v;
	endfunction

	// Random operand with weight on the edges and on small values.
	function automatic longint pick_operand();
		case ($urandom_range(0, 7))
			0: return MAX64;
			1: return MIN64;
			2: return longint'($urandom_range(0, 8)) - 4;
			3: return longint'($urandom_range(0, 130)) - 65;
			4: return longint'(int'($urandom()));
			5: return longint'(int'($urandom() >> $urandom_range(0, 31)));
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Sends one command transaction after a random gap; valid stays high
	// into the next transaction when there is no gap.
	task automatic send_command(cai_pkg::cmd_t c);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= c;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stimulus: directed table, then random commands.
	initial begin
		vec_t table_q[$];
		vec_t v;
		cai_pkg::cmd_t c;
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		rsp_if.ready = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		stim_done = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		table_q.push_back(row(cai_pkg::OP_ADD, MAX64, 1, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_SUB, MIN64, 1, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_MUL, MAX64, 2, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_DIV, 7, 0, 1, 0, cai_pkg::ST_DIV0));
		table_q.push_back(row(cai_pkg::OP_DIV, MIN64, -1, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_REM, MIN64, -1, 1, 0, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_MOD, MIN64, -1, 1, 0, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_REM, 5, 0, 1, 0, cai_pkg::ST_DIV0));
		table_q.push_back(row(cai_pkg::OP_MOD, -7, 3, 1, 2, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_MAX, MIN64, MAX64, 1, MAX64, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_MIN, MIN64, MAX64, 1, MIN64, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_AND, -1, 64'h0123_4567_89ab_cdef));
		table_q.push_back(row(cai_pkg::OP_OR, MIN64, 1));
		table_q.push_back(row(cai_pkg::OP_XOR, -1, MAX64, 1, MIN64, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_SHL, 1, 63, 1, MIN64, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_SHL, 1, 64, 1, 0, cai_pkg::ST_SHIFT));
		table_q.push_back(row(cai_pkg::OP_SHR, -1, -1, 1, 0, cai_pkg::ST_SHIFT));
		table_q.push_back(row(cai_pkg::OP_SHR, MIN64, 63, 1, 1, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_NOT, 0, 0, 1, -1, cai_pkg::ST_OK));
		table_q.push_back(row(cai_pkg::OP_NEG, MIN64, 0, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_ABS, MIN64, 0, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_PRED, MIN64, 0, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_SUCC, MAX64, 0, 1, 0, cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_SQUARE, 64'sd3037000500, 0, 1, 0,
			cai_pkg::ST_OVF));
		table_q.push_back(row(cai_pkg::OP_CUBE, -2097152, 0));
		for (int k = cai_pkg::OP_EQ; k <= 31; k++) table_q.push_back(row(5'(k), -3, 4));

		foreach (table_q[i]) begin
			v = table_q[i];
			rsp_expected_q.push_back(v.known ? v.rsp : alu_answer(v.cmd));
			send_command(v.cmd);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			c.operation = $urandom_range(0, 9) == 0 ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 25));
			c.operand_a = pick_operand();
			c.operand_b = pick_operand();
			if (c.operation inside {cai_pkg::OP_SHL, cai_pkg::OP_SHR}
					&& $urandom_range(0, 3) != 0)
				c.operand_b = 64'($urandom_range(0, 63));
			if (c.operation inside {cai_pkg::OP_SQUARE, cai_pkg::OP_CUBE}
					&& $urandom_range(0, 1))
				c.operand_a = longint'($urandom_range(0, 4194304)) - 2097152;
			rsp_expected_q.push_back(alu_answer(c));
			send_command(c);
		end
		cmd_if.valid <= 1'b0;
		stim_done = 1;
	end

	// Response side: random stalls, in-order checking.
	initial begin
		cai_pkg::rsp_t got, want;
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
			got = rsp_if.data;
			if (rsp_expected_q.size() == 0) begin
				$display("%0t: unexpected response result=%0d status=%0d",
					$realtime, got.result, got.status);
				errors++;
			end else begin
				want = rsp_expected_q.pop_front();
				if (got.result !== want.result)
					$display("%0t: result expected %0d actual %0d",
						$realtime, want.result, got.result);
				if (got.status !== want.status)
					$display("%0t: status expected %0d actual %0d",
						$realtime, want.status, got.status);
				if (got.result !== want.result || got.status !== want.status)
					errors++;
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End of run.
	initial begin
		wait (stim_done && rsp_expected_q.size() == 0 || idle_cycles >= WATCHDOG_LIMIT);
		if (idle_cycles < WATCHDOG_LIMIT) begin
			repeat (300) @(posedge clk);
			if (errors == 0)
				$display("checked_int64_alu_tb: clean");
			else
				$display("checked_int64_alu_tb: errors");
		end else begin
			$display("checked_int64_alu_tb: errors");
		end
		$finish;
	end

endmodule
